// ----- src/evg_pkg.sv -----
`default_nettype none

package evg_pkg;

    // Field formats
    typedef struct packed {
        logic [8:0] ring;
        logic [7:0] segment;
    } t_evg_in;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic               index_error;
    } t_evg_out;

    // Per-item control that rides beside the arithmetic
    typedef struct packed {
        logic err;
        logic pole_n;
        logic pole_s;
    } t_evg_flags;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RING_CNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_CNT   = 3'd4;

    localparam logic signed [15:0] SIZE_RST     = 16'sd256;
    localparam logic [8:0]         RING_CNT_RST = 9'd4;
    localparam logic [8:0]         SEG_CNT_RST  = 9'd8;

    localparam int MAX_RINGS          = 256;
    localparam int MAX_SEGMENTS       = 256;
    localparam int TRIG_FRAC_BITS_DEF = 15;

    // Angle divider: 32 quotient bits, four per stage
    localparam int DIV_BITS   = 32;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

    // Sine / cosine series at Q2.30
    localparam logic [31:0] PI_Q30    = 32'd3373259426;
    localparam int          SIN_TERMS = 5;
    localparam int          COS_TERMS = 6;

    // Divide by series constant k as (p * M) >> SH, exact for p < 2^30
    localparam int SIN_SH [SIN_TERMS] = '{37, 37, 36, 35, 33};
    localparam int COS_SH [COS_TERMS] = '{38, 37, 36, 35, 34, 31};

    localparam logic [30:0] SIN_M [SIN_TERMS] = '{
        31'(((64'd1 << 37) + 64'd109) / 64'd110),
        31'(((64'd1 << 37) + 64'd71) / 64'd72),
        31'(((64'd1 << 36) + 64'd41) / 64'd42),
        31'(((64'd1 << 35) + 64'd19) / 64'd20),
        31'(((64'd1 << 33) + 64'd5) / 64'd6)
    };
    localparam logic [30:0] COS_M [COS_TERMS] = '{
        31'(((64'd1 << 38) + 64'd131) / 64'd132),
        31'(((64'd1 << 37) + 64'd89) / 64'd90),
        31'(((64'd1 << 36) + 64'd55) / 64'd56),
        31'(((64'd1 << 35) + 64'd29) / 64'd30),
        31'(((64'd1 << 34) + 64'd11) / 64'd12),
        31'(((64'd1 << 31) + 64'd1) / 64'd2)
    };

    localparam int SC_STAGES = 3 + 2 * COS_TERMS;
    localparam int PIPE_LAT  = 1 + DIV_STAGES + SC_STAGES + 4;

    // Round v / 2^sh to nearest, half away from zero
    function automatic logic signed [63:0] rnd_away(input logic signed [63:0] v,
                                                    input int unsigned sh);
        logic [63:0] mag;
        logic [63:0] res;
        mag = v[63] ? 64'(-v) : 64'(v);
        if (sh == 0) begin
            res = mag;
        end else begin
            res = (mag + (64'd1 << (sh - 1))) >> sh;
        end
        return v[63] ? -$signed(res) : $signed(res);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] res;
        if (v > 64'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = 16'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/ellipsoid_vertex_generator_top.sv -----
// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+----------------------------------
// command   | start, busy, i_cmd (ring, segment)     | taken when start && !busy
// result    | o_valid, o_result (pos_x/y/z, error)   | one-cycle strobe, no back-pressure
// config    | i_cfg_we, i_cfg_idx, i_cfg_data        | written when i_cfg_we is high
//
// One item per clock while busy is low. Each item passes through the input
// register, the two 8-stage angle dividers, the 15-stage sine/cosine series
// pipes and four stages of scaling and rounding.
// Reset is synchronous, active low; busy is high while reset is held and low
// from the first cycle after, then stays low. Results cannot be stalled.
`default_nettype none

module ellipsoid_vertex_generator_top #(
    parameter int TRIG_FRAC_BITS = evg_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  evg_pkg::t_evg_in                 i_cmd,
    output logic                             o_valid,
    output evg_pkg::t_evg_out                o_result,
    input  logic                             i_cfg_we,
    input  logic [evg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [evg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import evg_pkg::*;

    localparam int TW     = TRIG_FRAC_BITS + 2;
    localparam int PW     = 16 + TW;
    localparam int FL_LEN = DIV_STAGES + SC_STAGES + 3;

    // ---------------- configuration registers ----------------
    logic signed [15:0] r_size_x;
    logic signed [15:0] r_size_y;
    logic signed [15:0] r_size_z;
    logic [8:0]         r_ring_cnt;
    logic [8:0]         r_seg_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x   <= SIZE_RST;
            r_size_y   <= SIZE_RST;
            r_size_z   <= SIZE_RST;
            r_ring_cnt <= RING_CNT_RST;
            r_seg_cnt  <= SEG_CNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SIZE_X:   r_size_x   <= i_cfg_data;
                REG_SIZE_Y:   r_size_y   <= i_cfg_data;
                REG_SIZE_Z:   r_size_z   <= i_cfg_data;
                REG_RING_CNT: r_ring_cnt <= i_cfg_data[8:0];
                REG_SEG_CNT:  r_seg_cnt  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Effective counts; config must be written only while idle (the block does
    // not enforce this), so every stage may read these directly.
    logic [8:0] w_stacks;
    logic [8:0] w_segs;

    assign w_stacks = (int'(r_ring_cnt) > MAX_RINGS) ? 9'(MAX_RINGS) : r_ring_cnt;
    assign w_segs   = (int'(r_seg_cnt) > MAX_SEGMENTS) ? 9'(MAX_SEGMENTS) : r_seg_cnt;

    // ---------------- accept and input stage ----------------
    logic r_busy;
    logic w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    // range check comes first, also for the poles
    t_evg_flags w_fl;
    assign w_fl.err    = (i_cmd.ring > w_stacks) || ({1'b0, i_cmd.segment} >= w_segs);
    assign w_fl.pole_n = (i_cmd.ring == 9'd0);
    assign w_fl.pole_s = (i_cmd.ring == w_stacks);

    logic       r_in_vld;
    t_evg_in    r_in_cmd;
    t_evg_flags r_in_fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= w_accept;
        end
        r_in_cmd <= i_cmd;
        r_in_fl  <= w_fl;
    end

    // flags ride beside the arithmetic up to the last multiply stage
    t_evg_flags r_fl [FL_LEN];

    always_ff @(posedge i_clk) begin
        r_fl[0] <= r_in_fl;
        for (int k = 1; k < FL_LEN; k++) begin
            r_fl[k] <= r_fl[k-1];
        end
    end

    // ---------------- angles as fractions of a turn ----------------
    // theta = round(ring / (2*stacks)), phi = round(segment / segs)
    logic                w_th_dvld;
    logic                w_ph_dvld;
    logic [DIV_BITS-1:0] w_th_ang;
    logic [DIV_BITS-1:0] w_ph_ang;

    evg_div #(
        .DW (10)
    ) u_div_th (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_vld),
        .i_rem   ({1'b0, r_in_cmd.ring}),
        .i_div   ({w_stacks, 1'b0}),
        .i_low   (DIV_BITS'(w_stacks)),
        .o_valid (w_th_dvld),
        .o_quot  (w_th_ang)
    );

    evg_div #(
        .DW (9)
    ) u_div_ph (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_vld),
        .i_rem   ({1'b0, r_in_cmd.segment}),
        .i_div   (w_segs),
        .i_low   (DIV_BITS'(w_segs[8:1])),
        .o_valid (w_ph_dvld),
        .o_quot  (w_ph_ang)
    );

    // ---------------- sine and cosine ----------------
    logic                 w_th_vld;
    logic                 w_ph_vld;
    logic signed [TW-1:0] w_st;
    logic signed [TW-1:0] w_ct;
    logic signed [TW-1:0] w_sp;
    logic signed [TW-1:0] w_cp;

    evg_sincos #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_sc_th (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_th_dvld && w_ph_dvld),
        .i_angle (w_th_ang),
        .o_valid (w_th_vld),
        .o_sin   (w_st),
        .o_cos   (w_ct)
    );

    evg_sincos #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_sc_ph (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_th_dvld && w_ph_dvld),
        .i_angle (w_ph_ang),
        .o_valid (w_ph_vld),
        .o_sin   (w_sp),
        .o_cos   (w_cp)
    );

    // ---------------- M1: sin(theta) * cos/sin(phi) ----------------
    logic                   r_m1_vld;
    logic signed [2*TW-1:0] r_m1_y;
    logic signed [2*TW-1:0] r_m1_z;
    logic signed [TW-1:0]   r_m1_ct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else begin
            r_m1_vld <= w_th_vld && w_ph_vld;
        end
        r_m1_y  <= (2*TW)'(w_st) * (2*TW)'(w_cp);
        r_m1_z  <= (2*TW)'(w_st) * (2*TW)'(w_sp);
        r_m1_ct <= w_ct;
    end

    // ---------------- R1: back to trig precision ----------------
    logic                 r_r1_vld;
    logic signed [TW-1:0] r_r1_y;
    logic signed [TW-1:0] r_r1_z;
    logic signed [TW-1:0] r_r1_ct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_vld <= 1'b0;
        end else begin
            r_r1_vld <= r_m1_vld;
        end
        r_r1_y  <= TW'(rnd_away(64'(r_m1_y), TRIG_FRAC_BITS));
        r_r1_z  <= TW'(rnd_away(64'(r_m1_z), TRIG_FRAC_BITS));
        r_r1_ct <= r_m1_ct;
    end

    // ---------------- M2: scale by semi-axes ----------------
    logic                 r_m2_vld;
    logic signed [PW-1:0] r_m2_x;
    logic signed [PW-1:0] r_m2_y;
    logic signed [PW-1:0] r_m2_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else begin
            r_m2_vld <= r_r1_vld;
        end
        r_m2_x <= PW'(r_size_x) * PW'(r_r1_ct);
        r_m2_y <= PW'(r_size_y) * PW'(r_r1_y);
        r_m2_z <= PW'(r_size_z) * PW'(r_r1_z);
    end

    // ---------------- R2: round, saturate, special cases ----------------
    t_evg_flags         w_ofl;
    logic signed [15:0] w_neg_x;
    t_evg_out           n_out;

    assign w_ofl   = r_fl[FL_LEN-1];
    // -(-32768) does not fit, clamp to the top
    assign w_neg_x = (r_size_x == 16'sh8000) ? 16'sh7FFF : -r_size_x;

    always_comb begin
        n_out.pos_x       = sat16(rnd_away(64'(r_m2_x), TRIG_FRAC_BITS));
        n_out.pos_y       = sat16(rnd_away(64'(r_m2_y), TRIG_FRAC_BITS));
        n_out.pos_z       = sat16(rnd_away(64'(r_m2_z), TRIG_FRAC_BITS));
        n_out.index_error = 1'b0;
        if (w_ofl.err) begin
            n_out.pos_x       = '0;
            n_out.pos_y       = '0;
            n_out.pos_z       = '0;
            n_out.index_error = 1'b1;
        end else if (w_ofl.pole_n) begin
            n_out.pos_x = r_size_x;
            n_out.pos_y = '0;
            n_out.pos_z = '0;
        end else if (w_ofl.pole_s) begin
            n_out.pos_x = w_neg_x;
            n_out.pos_y = '0;
            n_out.pos_z = '0;
        end
    end

    logic     r_out_vld;
    t_evg_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_m2_vld;
        end
        r_out <= n_out;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ----- src/evg_div.sv -----
`default_nettype none

// Pipelined restoring divider, quotient bits msb first.
module evg_div #(
    parameter int DW = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [DW-1:0]                 i_rem,
    input  logic [DW-1:0]                 i_div,
    input  logic [evg_pkg::DIV_BITS-1:0]  i_low,
    output logic                          o_valid,
    output logic [evg_pkg::DIV_BITS-1:0]  o_quot
);
    import evg_pkg::*;

    logic                r_vld  [DIV_STAGES];
    logic [DW-1:0]       r_rem  [DIV_STAGES];
    logic [DIV_BITS-1:0] r_low  [DIV_STAGES];
    logic [DIV_BITS-1:0] r_quot [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic                vld_in;
        logic [DW-1:0]       rem_in;
        logic [DIV_BITS-1:0] low_in;
        logic [DIV_BITS-1:0] quot_in;
        logic [DW-1:0]       n_rem;
        logic [DIV_BITS-1:0] n_low;
        logic [DIV_BITS-1:0] n_quot;

        if (s == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rem_in  = i_rem;
            assign low_in  = i_low;
            assign quot_in = '0;
        end else begin : g_next
            assign vld_in  = r_vld[s-1];
            assign rem_in  = r_rem[s-1];
            assign low_in  = r_low[s-1];
            assign quot_in = r_quot[s-1];
        end

        always_comb begin
            logic [DW:0] trial;
            logic [DW:0] diff;
            n_rem  = rem_in;
            n_low  = low_in;
            n_quot = quot_in;
            for (int k = 0; k < DIV_STEP; k++) begin
                trial = {n_rem, n_low[DIV_BITS-1]};
                diff  = trial - {1'b0, i_div};
                n_low = {n_low[DIV_BITS-2:0], 1'b0};
                if (trial >= {1'b0, i_div}) begin
                    n_rem  = diff[DW-1:0];
                    n_quot = {n_quot[DIV_BITS-2:0], 1'b1};
                end else begin
                    n_rem  = trial[DW-1:0];
                    n_quot = {n_quot[DIV_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
            r_rem[s]  <= n_rem;
            r_low[s]  <= n_low;
            r_quot[s] <= n_quot;
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quot  = r_quot[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- src/evg_sincos.sv -----
`default_nettype none

// Sine and cosine of an angle in 2^-32 turns: octant fold, Horner series,
// two register stages per series term.
module evg_sincos #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [31:0]                      i_angle,
    output logic                             o_valid,
    output logic signed [TRIG_FRAC_BITS+1:0] o_sin,
    output logic signed [TRIG_FRAC_BITS+1:0] o_cos
);
    import evg_pkg::*;

    localparam int          TW   = TRIG_FRAC_BITS + 2;
    localparam int          NH   = 2 * COS_TERMS;
    localparam int          RSH  = 30 - TRIG_FRAC_BITS;
    localparam logic [30:0] ONE  = 31'd1 << 30;
    localparam logic [29:0] HALF = 30'd1 << 29;

    // fold into [0, pi/4], x in Q0.30 radians
    logic [29:0] w_f;
    logic [29:0] w_h;
    logic        w_sw;
    logic [61:0] w_xp;

    assign w_f  = i_angle[29:0];
    assign w_sw = w_f > HALF;
    assign w_h  = w_sw ? 30'(ONE - {1'b0, w_f}) : w_f;
    assign w_xp = 62'(w_h) * 62'(PI_Q30) + (62'd1 << 30);

    logic        r0_vld;
    logic [29:0] r0_x;
    logic [1:0]  r0_q;
    logic        r0_sw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= i_valid;
        end
        r0_x  <= w_xp[60:31];
        r0_q  <= i_angle[31:30];
        r0_sw <= w_sw;
    end

    logic [59:0] w_x2p;
    assign w_x2p = 60'(r0_x) * 60'(r0_x);

    logic        r1_vld;
    logic [29:0] r1_x;
    logic [29:0] r1_x2;
    logic [1:0]  r1_q;
    logic        r1_sw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= r0_vld;
        end
        r1_x  <= r0_x;
        r1_x2 <= w_x2p[59:30];
        r1_q  <= r0_q;
        r1_sw <= r0_sw;
    end

    // Horner stages: even index multiplies by x^2, odd divides and subtracts
    logic        r_hv  [NH];
    logic [29:0] r_hx  [NH];
    logic [29:0] r_hx2 [NH];
    logic [1:0]  r_hq  [NH];
    logic        r_hsw [NH];
    logic [30:0] r_hc  [NH];
    logic [30:0] r_hs  [NH];

    for (genvar i = 0; i < COS_TERMS; i++) begin : g_term
        logic        v_in;
        logic [29:0] x_in;
        logic [29:0] x2_in;
        logic [1:0]  q_in;
        logic        sw_in;
        logic [30:0] tc_in;
        logic [30:0] ts_in;
        logic [60:0] w_pc;
        logic [60:0] w_ps;
        logic [61:0] w_dc;
        logic [61:0] w_ds;
        logic [30:0] w_ts;

        if (i == 0) begin : g_first
            assign v_in  = r1_vld;
            assign x_in  = r1_x;
            assign x2_in = r1_x2;
            assign q_in  = r1_q;
            assign sw_in = r1_sw;
            assign tc_in = ONE;
            assign ts_in = ONE;
        end else begin : g_next
            assign v_in  = r_hv[2*i-1];
            assign x_in  = r_hx[2*i-1];
            assign x2_in = r_hx2[2*i-1];
            assign q_in  = r_hq[2*i-1];
            assign sw_in = r_hsw[2*i-1];
            assign tc_in = r_hc[2*i-1];
            assign ts_in = r_hs[2*i-1];
        end

        assign w_pc = 61'(x2_in) * 61'(tc_in);
        if (i < SIN_TERMS) begin : g_sin_mul
            assign w_ps = 61'(x2_in) * 61'(ts_in);
        end else begin : g_sin_fin
            // last sine stage: sin = x * t
            assign w_ps = 61'(x_in) * 61'(ts_in);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hv[2*i] <= 1'b0;
            end else begin
                r_hv[2*i] <= v_in;
            end
            r_hx[2*i]  <= x_in;
            r_hx2[2*i] <= x2_in;
            r_hq[2*i]  <= q_in;
            r_hsw[2*i] <= sw_in;
            r_hc[2*i]  <= 31'(w_pc >> 30);
            r_hs[2*i]  <= 31'(w_ps >> 30);
        end

        assign w_dc = 62'(r_hc[2*i]) * 62'(COS_M[i]);
        if (i < SIN_TERMS) begin : g_sin_div
            assign w_ds = 62'(r_hs[2*i]) * 62'(SIN_M[i]);
            assign w_ts = ONE - 31'(w_ds >> SIN_SH[i]);
        end else begin : g_sin_hold
            assign w_ds = '0;
            assign w_ts = r_hs[2*i] | 31'(w_ds);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hv[2*i+1] <= 1'b0;
            end else begin
                r_hv[2*i+1] <= r_hv[2*i];
            end
            r_hx[2*i+1]  <= r_hx[2*i];
            r_hx2[2*i+1] <= r_hx2[2*i];
            r_hq[2*i+1]  <= r_hq[2*i];
            r_hsw[2*i+1] <= r_hsw[2*i];
            r_hc[2*i+1]  <= ONE - 31'(w_dc >> COS_SH[i]);
            r_hs[2*i+1]  <= w_ts;
        end
    end

    // unfold octant and quadrant, round to output precision
    logic [30:0]   w_s0;
    logic [30:0]   w_c0;
    logic [TW-1:0] w_sr;
    logic [TW-1:0] w_cr;
    logic [TW-1:0] w_smag;
    logic [TW-1:0] w_cmag;
    logic          w_sneg;
    logic          w_cneg;

    assign w_s0   = r_hsw[NH-1] ? r_hc[NH-1] : r_hs[NH-1];
    assign w_c0   = r_hsw[NH-1] ? r_hs[NH-1] : r_hc[NH-1];
    assign w_sr   = TW'(rnd_away(64'(w_s0), RSH));
    assign w_cr   = TW'(rnd_away(64'(w_c0), RSH));
    assign w_smag = r_hq[NH-1][0] ? w_cr : w_sr;
    assign w_cmag = r_hq[NH-1][0] ? w_sr : w_cr;
    assign w_sneg = r_hq[NH-1][1];
    assign w_cneg = r_hq[NH-1][1] ^ r_hq[NH-1][0];

    logic                 r_out_vld;
    logic signed [TW-1:0] r_sin;
    logic signed [TW-1:0] r_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_hv[NH-1];
        end
        r_sin <= w_sneg ? -$signed(w_smag) : $signed(w_smag);
        r_cos <= w_cneg ? -$signed(w_cmag) : $signed(w_cmag);
    end

    assign o_valid = r_out_vld;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

`default_nettype wire

// ----- src/evg_checker.sv -----
`default_nettype none

module evg_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  evg_pkg::t_evg_in  i_cmd,
    input  logic              o_valid,
    input  evg_pkg::t_evg_out o_result
);
    import evg_pkg::*;

    logic w_acc;
    assign w_acc = start && !busy;

    // every item comes out after the fixed latency
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##PIPE_LAT o_valid)
        else $error("accepted item produced no result");

    // no result without an item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_acc, PIPE_LAT))
        else $error("result without a matching item");

    // a ring beyond any possible count is always flagged
    a_ring_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (int'(i_cmd.ring) > MAX_RINGS)) |->
            ##PIPE_LAT (o_valid && o_result.index_error))
        else $error("out-of-range ring not flagged");

    // flagged results carry zero coordinates
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.index_error) |->
            (o_result.pos_x == 16'sd0 && o_result.pos_y == 16'sd0 &&
             o_result.pos_z == 16'sd0))
        else $error("error result with nonzero coordinates");

endmodule

bind ellipsoid_vertex_generator_top evg_checker u_evg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire

// ----- verif/ellipsoid_vertex_generator_top_tb.sv -----
`timescale 1ns / 1ps

module ellipsoid_vertex_generator_top_tb;
    import evg_pkg::*;

    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint unsigned PI30 = 64'd3373259426;
    localparam int TFB = TRIG_FRAC_BITS_DEF;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_evg_in i_cmd = '0;
    logic o_valid;
    t_evg_out o_result;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ellipsoid_vertex_generator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_valid(o_valid), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the configuration registers
    logic signed [15:0] size_x_m, size_y_m, size_z_m;
    logic [8:0] ring_cnt_m, seg_cnt_m;

    // Vertices still owed by the block, oldest first
    t_evg_out vertex_q[$];
    int fail_count = 0;
    int stall_cycles = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // ---------------------------------------------------------------------
    // Vertex predictor: fixed-point trig, bit exact
    // ---------------------------------------------------------------------
    function automatic longint rnd_near(input longint v, input int sh);
        longint unsigned mag;
        mag = (v < 0) ? longint'(-v) : v;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint unsigned sin_series(input longint unsigned x);
        longint unsigned kd[5] = '{110, 72, 42, 20, 6};
        longint unsigned x2, t;
        x2 = (x * x) >> 30;
        t = Q30;
        for (int i = 0; i < 5; i++) t = Q30 - ((x2 * t) >> 30) / kd[i];
        return (x * t) >> 30;
    endfunction

    function automatic longint unsigned cos_series(input longint unsigned x);
        longint unsigned kd[6] = '{132, 90, 56, 30, 12, 2};
        longint unsigned x2, t;
        x2 = (x * x) >> 30;
        t = Q30;
        for (int i = 0; i < 6; i++) t = Q30 - ((x2 * t) >> 30) / kd[i];
        return t;
    endfunction

    // Angle in 2^-32 turns -> sine and cosine at TFB fraction bits
    function automatic void turn_trig(input logic [31:0] ang, output longint s,
                                      output longint c);
        longint unsigned frac, x;
        longint s0, c0, rs, rc;
        frac = ang[29:0];
        if (frac <= (64'd1 << 29)) begin
            x = (frac * PI30 + (64'd1 << 30)) >> 31;
            s0 = sin_series(x);
            c0 = cos_series(x);
        end else begin
            x = ((Q30 - frac) * PI30 + (64'd1 << 30)) >> 31;
            s0 = cos_series(x);
            c0 = sin_series(x);
        end
        case (ang[31:30])
            2'd0: begin rs = s0; rc = c0; end
            2'd1: begin rs = c0; rc = -s0; end
            2'd2: begin rs = -s0; rc = -c0; end
            default: begin rs = -c0; rc = s0; end
        endcase
        s = rnd_near(rs, 30 - TFB);
        c = rnd_near(rc, 30 - TFB);
    endfunction

    function automatic logic signed [15:0] scale_clip(input longint dim, input longint trig);
        longint v;
        v = rnd_near(dim * trig, TFB);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic t_evg_out vertex_of(input t_evg_in c);
        t_evg_out r;
        longint unsigned stacks, segs, rg, sg;
        longint st, ct, sp, cp, neg_x;
        logic [31:0] ta, pa;
        r = '0;
        rg = c.ring;
        sg = c.segment;
        stacks = (ring_cnt_m > MAX_RINGS) ? MAX_RINGS : ring_cnt_m;
        segs = (seg_cnt_m > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_cnt_m;
        if (rg > stacks || sg >= segs) begin
            r.index_error = 1'b1;
        end else if (rg == 0) begin
            r.pos_x = size_x_m;
        end else if (rg == stacks) begin
            neg_x = -longint'(size_x_m);
            r.pos_x = (neg_x > 32767) ? 16'sh7FFF : 16'(neg_x);
        end else begin
            ta = 32'(((rg << 32) + stacks) / (2 * stacks));
            pa = 32'(((sg << 32) + segs / 2) / segs);
            turn_trig(ta, st, ct);
            turn_trig(pa, sp, cp);
            r.pos_x = scale_clip(size_x_m, ct);
            r.pos_y = scale_clip(size_y_m, rnd_near(st * cp, TFB));
            r.pos_z = scale_clip(size_z_m, rnd_near(st * sp, TFB));
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Result checker and watchdog
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_evg_out exp_v;
        if (i_rst_n && o_valid) begin
            if (vertex_q.size() == 0) begin
                report_mismatch("vertex with none outstanding");
            end else begin
                exp_v = vertex_q.pop_front();
                if (o_result.pos_x !== exp_v.pos_x)
                    report_mismatch($sformatf("pos_x %0d exp %0d", o_result.pos_x, exp_v.pos_x));
                if (o_result.pos_y !== exp_v.pos_y)
                    report_mismatch($sformatf("pos_y %0d exp %0d", o_result.pos_y, exp_v.pos_y));
                if (o_result.pos_z !== exp_v.pos_z)
                    report_mismatch($sformatf("pos_z %0d exp %0d", o_result.pos_z, exp_v.pos_z));
                if (o_result.index_error !== exp_v.index_error)
                    report_mismatch($sformatf("index_error %0b exp %0b",
                                              o_result.index_error, exp_v.index_error));
            end
        end
        // Count cycles with no traffic in either direction
        if ((i_rst_n && start && !busy) || o_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_SIZE_X: size_x_m = val;
            REG_SIZE_Y: size_y_m = val;
            REG_SIZE_Z: size_z_m = val;
            REG_RING_CNT: ring_cnt_m = val[8:0];
            REG_SEG_CNT: seg_cnt_m = val[8:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Send one item; queue either the typed-in vertex or the predicted one
    task automatic send_item(input t_evg_in c, input bit typed, input t_evg_out typed_v,
                             input int gap);
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        vertex_q = {vertex_q, (typed ? typed_v : vertex_of(c))};
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic int pick_gap(input bit quiet);
        int p;
        p = $urandom_range(0, 99);
        if (quiet || p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Wait until every queued vertex is back, then let the pipe settle
    task automatic drain();
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    typedef struct {
        logic [8:0] ring;
        logic [7:0] segment;
        bit typed;
        logic signed [15:0] x, y, z;
        bit err;
    } t_row;

    // Directed rows at reset settings: 4 rings, 8 segments, sphere of radius 256
    t_row directed[] = '{
        '{9'd0, 8'd0, 1, 16'sd256, 16'sd0, 16'sd0, 0},       // north pole
        '{9'd0, 8'd7, 1, 16'sd256, 16'sd0, 16'sd0, 0},
        '{9'd4, 8'd3, 1, -16'sd256, 16'sd0, 16'sd0, 0},      // south pole
        '{9'd5, 8'd0, 1, 16'sd0, 16'sd0, 16'sd0, 1},         // ring past pole
        '{9'd0, 8'd8, 1, 16'sd0, 16'sd0, 16'sd0, 1},         // segment off the end
        '{9'd511, 8'd255, 1, 16'sd0, 16'sd0, 16'sd0, 1},     // all ones
        '{9'd256, 8'd0, 1, 16'sd0, 16'sd0, 16'sd0, 1},
        '{9'd2, 8'd0, 0, 0, 0, 0, 0},                         // equator
        '{9'd2, 8'd2, 0, 0, 0, 0, 0},
        '{9'd2, 8'd4, 0, 0, 0, 0, 0},
        '{9'd1, 8'd1, 0, 0, 0, 0, 0},
        '{9'd3, 8'd5, 0, 0, 0, 0, 0},
        '{9'd1, 8'd6, 0, 0, 0, 0, 0},
        '{9'd3, 8'd7, 0, 0, 0, 0, 0}
    };

    // Per phase: size_x, size_y, size_z, ring_count, segment_count
    logic [15:0] phase_cfg[5][5] = '{
        '{16'h8000, 16'h7FFF, 16'h8000, 16'd256, 16'd256},  // widest, extreme sizes
        '{16'h7FFF, 16'h8000, 16'h7FFF, 16'd2, 16'd3},      // coarsest legal
        '{16'h8000, 16'h0100, 16'h0100, 16'd1, 16'd0},      // no segments at all
        '{16'h03E8, 16'hFD44, 16'h01F4, 16'd0, 16'd511},    // zero rings, clamped segs
        '{16'h0100, 16'h0100, 16'h0100, 16'd511, 16'd5}     // clamped rings
    };

    initial begin
        t_evg_in c;
        t_evg_out tv;
        int stacks, segs;
        bit quiet;

        size_x_m = SIZE_RST;
        size_y_m = SIZE_RST;
        size_z_m = SIZE_RST;
        ring_cnt_m = RING_CNT_RST;
        seg_cnt_m = SEG_CNT_RST;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: typed rows checked as written, the rest by prediction
        foreach (directed[i]) begin
            c.ring = directed[i].ring;
            c.segment = directed[i].segment;
            tv.pos_x = directed[i].x;
            tv.pos_y = directed[i].y;
            tv.pos_z = directed[i].z;
            tv.index_error = directed[i].err;
            send_item(c, directed[i].typed, tv, pick_gap(0));
        end

        // Random phases; each change of settings waits for the pipe to empty
        for (int ph = 0; ph < 8; ph++) begin
            @(negedge i_clk);
            start <= 1'b0;
            drain();
            if (ph < 5) begin
                for (int r = 0; r < 5; r++) write_reg(CFG_IDX_W'(r), phase_cfg[ph][r]);
            end else begin
                write_reg(REG_SIZE_X, 16'($urandom));
                write_reg(REG_SIZE_Y, 16'($urandom));
                write_reg(REG_SIZE_Z, 16'($urandom));
                write_reg(REG_RING_CNT, 16'($urandom_range(2, 64)));
                write_reg(REG_SEG_CNT, 16'($urandom_range(3, 64)));
            end
            stacks = (ring_cnt_m > MAX_RINGS) ? MAX_RINGS : ring_cnt_m;
            segs = (seg_cnt_m > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_cnt_m;
            quiet = (ph == 2 || ph == 6);   // back-to-back phases
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 85) c.ring = 9'($urandom_range(0, stacks));
                else c.ring = 9'($urandom);
                if (segs > 0 && $urandom_range(0, 99) < 85)
                    c.segment = 8'($urandom_range(0, segs - 1));
                else c.segment = 8'($urandom);
                send_item(c, 0, '0, pick_gap(quiet));
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        drain();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/evg_pkg.sv
src/evg_div.sv
src/evg_sincos.sv
src/ellipsoid_vertex_generator_top.sv
src/evg_checker.sv
verif/ellipsoid_vertex_generator_top_tb.sv
